// File: design/ipu_pkg.sv
// shared types and constants for the integer pixel replication upscaler
// no dependencies
`timescale 1ns / 1ps

package ipu_pkg;

  // input opcodes
  localparam logic OP_PIXEL  = 1'b0;
  localparam logic OP_REPLAY = 1'b1;

  // register indexes on the configuration port
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_SCALE      = 1'b1;

  // run length field, wide enough for the largest supported scale
  localparam int CNT_W = 7;

  // command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_LVL_W = 3;

  // one classified word handed from front to back
  typedef struct packed {
    logic [23:0]      pix;
    logic             eol;
    logic             rejected;
    logic [CNT_W-1:0] copies;
  } cmd_t;

endpackage

// File: design/ipu_ram.sv
// generic single port ram, registered read (read-before-write)
// no dependencies
`timescale 1ns / 1ps

module ipu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/ipu_front.sv
// front: accepts input words, tracks line/pass state, owns the line store
// depends on ipu_pkg and ipu_ram
`timescale 1ns / 1ps

module ipu_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [7:0]                  in_red_in,
  input  logic [7:0]                  in_green_in,
  input  logic [7:0]                  in_blue_in,
  input  logic [10:0]                 line_width,
  input  logic [4:0]                  scale,
  input  logic [ipu_pkg::Q_LVL_W-1:0] q_level,
  output logic                        push_valid,
  output ipu_pkg::cmd_t               push_cmd
);

  import ipu_pkg::*;

  localparam int CLW = $clog2(MAX_WIDTH);
  localparam int EWW = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_SCALE);
  localparam int ESW = $clog2(MAX_SCALE + 1);

  logic [CLW-1:0] column_r, column_nxt;
  logic [RW-1:0]  repeat_r, repeat_nxt;
  logic           phase_r, phase_nxt;
  logic           s1_valid_r;
  logic           s1_replay_r;
  cmd_t           s1_cmd_r;

  logic [EWW-1:0] eff_w;
  logic [ESW-1:0] eff_s;
  logic           accept;
  logic           phase_ok;
  logic           eol;
  logic           ram_we;
  logic [23:0]    ram_rdata;
  logic [23:0]    src_pix;

  // clamp the registers to their usable range
  always_comb begin
    if (line_width == 11'd0) begin
      eff_w = EWW'(1);
    end else if (int'(line_width) > MAX_WIDTH) begin
      eff_w = EWW'(MAX_WIDTH);
    end else begin
      eff_w = EWW'(line_width);
    end
    if (scale == 5'd0) begin
      eff_s = ESW'(1);
    end else if (int'(scale) > MAX_SCALE) begin
      eff_s = ESW'(MAX_SCALE);
    end else begin
      eff_s = ESW'(scale);
    end
  end

  // room for this word and the one still in stage one
  assign in_stall = ((Q_LVL_W + 1)'(q_level) + (Q_LVL_W + 1)'(s1_valid_r))
                    >= (Q_LVL_W + 1)'(Q_DEPTH);

  assign accept   = in_valid && !in_stall;
  assign phase_ok = (in_opcode == OP_REPLAY) == phase_r;
  assign eol      = (int'(column_r) + 1) >= int'(eff_w);
  assign src_pix  = {in_red_in, in_green_in, in_blue_in};
  assign ram_we   = accept && phase_ok && (in_opcode == OP_PIXEL);

  // column, pass count and phase
  always_comb begin
    column_nxt = column_r;
    repeat_nxt = repeat_r;
    phase_nxt  = phase_r;
    if (accept && phase_ok) begin
      if (!eol) begin
        column_nxt = column_r + 1'b1;
      end else begin
        column_nxt = '0;
        if (in_opcode == OP_PIXEL) begin
          repeat_nxt = '0;
          phase_nxt  = (int'(eff_s) > 1);
        end else if ((int'(repeat_r) + 2) >= int'(eff_s)) begin
          repeat_nxt = '0;
          phase_nxt  = 1'b0;
        end else begin
          repeat_nxt = repeat_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      repeat_r   <= '0;
      phase_r    <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      column_r   <= column_nxt;
      repeat_r   <= repeat_nxt;
      phase_r    <= phase_nxt;
      s1_valid_r <= accept;
    end
  end

  // stage one payload, waits for the store read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_replay_r       <= phase_ok && (in_opcode == OP_REPLAY);
      s1_cmd_r.rejected <= !phase_ok;
      s1_cmd_r.eol      <= phase_ok && eol;
      s1_cmd_r.pix      <= phase_ok ? src_pix : 24'd0;
      s1_cmd_r.copies   <= phase_ok ? CNT_W'(eff_s) : CNT_W'(1);
    end
  end

  // line store
  ipu_ram #(
    .WIDTH(24),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (column_r),
    .wdata(src_pix),
    .rdata(ram_rdata)
  );

  // hand the word to the queue
  always_comb begin
    push_cmd = s1_cmd_r;
    if (s1_replay_r) begin
      push_cmd.pix = ram_rdata;
    end
  end
  assign push_valid = s1_valid_r;

endmodule

// File: design/ipu_queue.sv
// small command queue between front and back
// depends on ipu_pkg
`timescale 1ns / 1ps

module ipu_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  ipu_pkg::cmd_t               push_cmd,
  input  logic                        pop,
  output ipu_pkg::cmd_t               head,
  output logic                        head_valid,
  output logic [ipu_pkg::Q_LVL_W-1:0] level
);

  import ipu_pkg::*;

  cmd_t               slots_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_LVL_W-1:0] level_r, level_nxt;

  // occupancy
  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      level_r <= level_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head       = slots_r[rd_ptr_r];
  assign head_valid = (level_r != '0);
  assign level      = level_r;

endmodule

// File: design/ipu_back.sv
// back: expands each queued word into its run of output pixels
// depends on ipu_pkg
`timescale 1ns / 1ps

module ipu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ipu_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_red_out,
  output logic [7:0]    out_green_out,
  output logic [7:0]    out_blue_out,
  output logic          out_line_end,
  output logic          out_rejected,
  output logic          out_last_of_run
);

  import ipu_pkg::*;

  logic [CNT_W-1:0] copy_r, copy_nxt;
  logic             out_valid_r;
  logic [23:0]      pix_r;
  logic             line_end_r;
  logic             rejected_r;
  logic             last_r;
  logic             load;
  logic             last;

  // output register frees up when empty or taken
  assign load = !out_valid_r || !out_stall;
  assign last = (copy_r + 1'b1) == head.copies;
  assign pop  = load && head_valid && last;

  always_comb begin
    copy_nxt = copy_r;
    if (load && head_valid) begin
      copy_nxt = last ? '0 : copy_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      copy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      copy_r <= copy_nxt;
      if (load) begin
        out_valid_r <= head_valid;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      pix_r      <= head.pix;
      line_end_r <= last && head.eol;
      rejected_r <= head.rejected;
      last_r     <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_out     = pix_r[23:16];
  assign out_green_out   = pix_r[15:8];
  assign out_blue_out    = pix_r[7:0];
  assign out_line_end    = line_end_r;
  assign out_rejected    = rejected_r;
  assign out_last_of_run = last_r;

endmodule

// File: design/integer_pixel_replication_upscaler.sv
// top level: register port, front, command queue and back of the upscaler
// depends on ipu_pkg, ipu_front, ipu_queue, ipu_back
// path: a word goes via the stage-one register, the queue and the output register
// throughput: one result per cycle while out is not stalled; a word gives the back
// one result per copy (one for a rejected word) and is popped with its last copy
// reset: synchronous active low; clears line/pass state, queue and output valid
`timescale 1ns / 1ps

module integer_pixel_replication_upscaler #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_line_end,
  output logic        out_rejected,
  output logic        out_last_of_run
);

  import ipu_pkg::*;

  logic [10:0]        line_width_r;
  logic [4:0]         scale_r;
  logic               cfg_wr;
  logic               push_valid;
  cmd_t               push_cmd;
  cmd_t               head;
  logic               head_valid;
  logic               pop;
  logic [Q_LVL_W-1:0] q_level;

  // register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= 11'd1;
      scale_r      <= 5'd1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_LINE_WIDTH: line_width_r <= pwdata[10:0];
        REG_SCALE:      scale_r      <= pwdata[4:0];
        default:        ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[2])
      REG_LINE_WIDTH: prdata = {21'd0, line_width_r};
      REG_SCALE:      prdata = {27'd0, scale_r};
      default:        prdata = 32'd0;
    endcase
  end

  ipu_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_SCALE(MAX_SCALE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_red_in  (in_red_in),
    .in_green_in(in_green_in),
    .in_blue_in (in_blue_in),
    .line_width (line_width_r),
    .scale      (scale_r),
    .q_level    (q_level),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  ipu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid),
    .level     (q_level)
  );

  ipu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_line_end   (out_line_end),
    .out_rejected   (out_rejected),
    .out_last_of_run(out_last_of_run)
  );

  // queue never overflows
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_level < Q_LVL_W'(Q_DEPTH)) || (q_level == Q_LVL_W'(Q_DEPTH) && !push_valid))
    else $error("command queue overflow");

  // a rejected word is a single blank result
  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rejected) |->
      (out_last_of_run && !out_line_end && out_red_out == 8'd0 &&
       out_green_out == 8'd0 && out_blue_out == 8'd0))
    else $error("malformed rejected result");

  // a line ends only on the last copy of a run
  a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_end) |-> out_last_of_run)
    else $error("line end inside a run");

endmodule

// File: dv/integer_pixel_replication_upscaler_test.sv
// self-checking testbench for the integer pixel replication upscaler: directed table, then random
// segments under varied idling; depends on ipu_pkg and integer_pixel_replication_upscaler
`timescale 1ns / 1ps

module integer_pixel_replication_upscaler_test;
  import ipu_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int SCALE_LIMIT = 16;
  localparam logic [2:0] ADDR_LINE_WIDTH = {REG_LINE_WIDTH, 2'b00};
  localparam logic [2:0] ADDR_SCALE = {REG_SCALE, 2'b00};
  localparam int SEGMENTS = 8;
  localparam int WORDS_PER_SEGMENT = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       line_end;
    logic       rejected;
    logic       last_of_run;
  } pixel_result_t;

  typedef struct packed {
    logic          is_reg;
    logic [2:0]    addr;
    logic [31:0]   value;
    logic          op;
    logic [23:0]   rgb;
    logic          typed;
    pixel_result_t want;
  } plan_row_t;

  localparam pixel_result_t REJECTED_WORD = pixel_result_t'{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = OP_PIXEL;
  logic [7:0]  in_red_in = '0;
  logic [7:0]  in_green_in = '0;
  logic [7:0]  in_blue_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red_out;
  logic [7:0]  out_green_out;
  logic [7:0]  out_blue_out;
  logic        out_line_end;
  logic        out_rejected;
  logic        out_last_of_run;

  integer_pixel_replication_upscaler dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: line store, position, pass count and register copies
  logic [23:0]            px_store [STORE_DEPTH];
  bit [STORE_DEPTH-1:0]   written_mask = '0;
  int unsigned            pred_col = 0;
  int unsigned            pred_passes = 0;
  logic                   replay_on = 1'b0;
  logic [10:0]            width_reg = 11'd1;
  logic [4:0]             scale_reg = 5'd1;
  pixel_result_t          expected_pixels [$];

  int   fail_count = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  pixel_result_t oldest;

  function automatic int unsigned eff_width(logic [10:0] w);
    if (w == 0) return 1;
    if (w > STORE_DEPTH) return STORE_DEPTH;
    return w;
  endfunction

  // expected output run for one accepted word, advancing the line and pass state
  function automatic void replicate_word(logic op, logic [23:0] rgb);
    int unsigned   w;
    int unsigned   s;
    int unsigned   k;
    logic [23:0]   pix;
    logic          eol;
    pixel_result_t res;
    w = eff_width(width_reg);
    s = (scale_reg == 0) ? 1 : ((scale_reg > SCALE_LIMIT) ? SCALE_LIMIT : scale_reg);
    if (op != replay_on) begin
      expected_pixels.push_back(REJECTED_WORD);
      return;
    end
    eol = (pred_col + 1 >= w);
    if (op == OP_PIXEL) begin
      pix = rgb;
      px_store[pred_col] = rgb;
      written_mask[pred_col] = 1'b1;
    end else begin
      pix = px_store[pred_col];
    end
    for (k = 0; k < s; k++) begin
      res.red = pix[23:16];
      res.green = pix[15:8];
      res.blue = pix[7:0];
      res.line_end = (k == s - 1) && eol;
      res.rejected = 1'b0;
      res.last_of_run = (k == s - 1);
      expected_pixels.push_back(res);
    end
    if (eol) begin
      pred_col = 0;
      if (op == OP_PIXEL) begin
        pred_passes = 0;
        if (s > 1) replay_on = 1'b1;
      end else begin
        pred_passes++;
        if (pred_passes + 1 >= s) begin
          pred_passes = 0;
          replay_on = 1'b0;
        end
      end
    end else begin
      pred_col++;
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic compare_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // result side: check each accepted word, then decide the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        oldest = expected_pixels.pop_front();
        compare_field("red_out", out_red_out, oldest.red);
        compare_field("green_out", out_green_out, oldest.green);
        compare_field("blue_out", out_blue_out, oldest.blue);
        compare_field("line_end", out_line_end, oldest.line_end);
        compare_field("rejected", out_rejected, oldest.rejected);
        compare_field("last_of_run", out_last_of_run, oldest.last_of_run);
      end
    end
    // one long hold-off so the block backs up into its input
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) hold_left--;
    out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
  end

  // offer one word and hold it until accepted
  task automatic send_word(logic op, logic [23:0] rgb);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_red_in <= rgb[23:16];
    in_green_in <= rgb[15:8];
    in_blue_in <= rgb[7:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    replicate_word(op, rgb);
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // register write: setup cycle, then access cycle
  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_LINE_WIDTH) width_reg = value[10:0];
    else scale_reg = value[4:0];
    @(posedge clk);
  endtask

  function automatic plan_row_t word_row(logic op, logic [23:0] rgb);
    plan_row_t row;
    row = '0;
    row.op = op;
    row.rgb = rgb;
    return row;
  endfunction

  function automatic plan_row_t typed_row(logic op, logic [23:0] rgb, pixel_result_t want);
    plan_row_t row;
    row = word_row(op, rgb);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [2:0] addr, logic [31:0] value);
    plan_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.addr = addr;
    row.value = value;
    return row;
  endfunction

  // run limit
  initial begin
    #4_000_000;
    $display("integer_pixel_replication_upscaler regression: fail");
    $finish;
  end

  initial begin
    plan_row_t   plan [$];
    int          seg;
    int          n;
    int          first_gap;
    logic        op;
    logic [10:0] width_pick;
    logic [4:0]  new_scale;

    // after reset: width one, scale one, so each pixel is a whole line
    plan.push_back(typed_row(OP_PIXEL, 24'hff0080,
                             pixel_result_t'{8'hff, 8'h00, 8'h80, 1'b1, 1'b0, 1'b1}));
    plan.push_back(typed_row(OP_REPLAY, 24'hffffff, REJECTED_WORD));
    plan.push_back(typed_row(OP_PIXEL, 24'h000000,
                             pixel_result_t'{8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1}));
    // three-pixel line doubled, with a pixel sent during replay
    plan.push_back(reg_row(ADDR_LINE_WIDTH, 32'd3));
    plan.push_back(reg_row(ADDR_SCALE, 32'd2));
    plan.push_back(word_row(OP_PIXEL, 24'hffffff));
    plan.push_back(word_row(OP_PIXEL, 24'h010204));
    plan.push_back(word_row(OP_PIXEL, 24'h804020));
    plan.push_back(typed_row(OP_PIXEL, 24'h123456, REJECTED_WORD));
    plan.push_back(word_row(OP_REPLAY, 24'h000000));
    plan.push_back(word_row(OP_REPLAY, 24'h000000));
    plan.push_back(word_row(OP_REPLAY, 24'h000000));
    // zero registers act as one
    plan.push_back(reg_row(ADDR_LINE_WIDTH, 32'd0));
    plan.push_back(reg_row(ADDR_SCALE, 32'd0));
    plan.push_back(typed_row(OP_PIXEL, 24'haa55aa,
                             pixel_result_t'{8'haa, 8'h55, 8'haa, 1'b1, 1'b0, 1'b1}));
    // oversized registers clamp to the maximum
    plan.push_back(reg_row(ADDR_LINE_WIDTH, 32'd2047));
    plan.push_back(reg_row(ADDR_SCALE, 32'd31));
    plan.push_back(word_row(OP_PIXEL, 24'h7f7f7f));
    plan.push_back(word_row(OP_PIXEL, 24'h808080));
    // width shrunk below the column mid-line: line ends on the next pixel
    plan.push_back(reg_row(ADDR_LINE_WIDTH, 32'd2));
    plan.push_back(word_row(OP_PIXEL, 24'hfe01fe));
    plan.push_back(reg_row(ADDR_SCALE, 32'd16));
    plan.push_back(word_row(OP_REPLAY, 24'h000000));
    plan.push_back(word_row(OP_REPLAY, 24'h000000));
    // scale dropped mid-replay: replay stops at the end of this pass
    plan.push_back(reg_row(ADDR_SCALE, 32'd1));
    plan.push_back(word_row(OP_REPLAY, 24'h000000));
    plan.push_back(word_row(OP_REPLAY, 24'h000000));
    plan.push_back(reg_row(ADDR_LINE_WIDTH, 32'd1024));
    plan.push_back(typed_row(OP_PIXEL, 24'h0f0f0f,
                             pixel_result_t'{8'h0f, 8'h0f, 8'h0f, 1'b0, 1'b0, 1'b1}));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        wait_drained();
        write_reg(plan[i].addr, plan[i].value);
      end else begin
        send_word(plan[i].op, plan[i].rgb);
        if (plan[i].typed) begin
          void'(expected_pixels.pop_back());
          expected_pixels.push_back(plan[i].want);
        end
        idle_gap();
      end
    end

    // random segments: none, sender idle, receiver stall, both
    for (seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      gap_pct = (seg % 4 == 1) ? 47 : ((seg % 4 == 3) ? 14 : 0);
      stall_pct = (seg % 4 == 2) ? 47 : ((seg % 4 == 3) ? 14 : 0);
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(2))
          0: width_pick = 11'd0;
          1: width_pick = 11'd1024;
          default: width_pick = 11'd2047;
        endcase
      end else begin
        width_pick = 11'($urandom_range(1, 6));
      end
      // during replay never widen past the stored part of the line
      first_gap = 0;
      while (first_gap < STORE_DEPTH && written_mask[first_gap]) first_gap++;
      if (replay_on && eff_width(width_pick) > first_gap) width_pick = first_gap[10:0];
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(2))
          0: new_scale = 5'd0;
          1: new_scale = 5'd16;
          default: new_scale = 5'd31;
        endcase
      end else begin
        new_scale = 5'($urandom_range(1, 4));
      end
      write_reg(ADDR_LINE_WIDTH, {21'd0, width_pick});
      write_reg(ADDR_SCALE, {27'd0, new_scale});
      if (seg == 4) hold_go = 1'b1;
      for (n = 0; n < WORDS_PER_SEGMENT; n++) begin
        // mostly the opcode the current phase wants, some out of phase
        op = replay_on ? OP_REPLAY : OP_PIXEL;
        if ($urandom_range(99) < 10) op = ~op;
        send_word(op, 24'($urandom_range(24'hffffff)));
        idle_gap();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("integer_pixel_replication_upscaler regression: pass");
    end else begin
      $display("integer_pixel_replication_upscaler regression: fail");
    end
    $finish;
  end

endmodule
